/* hdl/sbc_pkg.sv */
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared constants for the swept box collision pipeline: direction
// precision, lane latencies and normal codes.
// ----------------------------------------------------------------------------
`default_nettype none

package sbc_pkg;

    // Unit direction precision (Q0.DIR_BITS) and lane depths
    localparam int DIR_BITS   = 16;
    localparam int DIV_STEPS  = 2 * DIR_BITS;
    localparam int DIR_LAT    = DIV_STEPS + DIR_BITS;

    // Normal component codes
    typedef logic signed [1:0] t_norm;
    localparam t_norm NORM_NONE = 2'sb00;
    localparam t_norm NORM_POS  = 2'sb01;
    localparam t_norm NORM_NEG  = 2'sb11;

endpackage

`default_nettype wire

/* hdl/sbc_div_pipe.sv */
// ----------------------------------------------------------------------------
// sbc_div_pipe
// Pipelined restoring divider, one quotient bit per stage. Expects the
// numerator below the divisor; returns floor(num * 2^QW / den).
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_div_pipe #(
    parameter int NW = 48,
    parameter int QW = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [NW-1:0] i_den,
    output logic      [QW-1:0] o_quo
);

    logic [NW-1:0] r_rem [QW];
    logic [NW-1:0] r_den [QW];
    logic [QW-1:0] r_quo [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [NW-1:0] rem_in;
        logic [NW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [NW:0]   shifted;
        logic [NW:0]   diff;
        logic          ge;
        logic [NW-1:0] n_rem;

        if (k == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign quo_in = r_quo[k-1];
        end

        // Shift in a zero and subtract the divisor when it fits
        always_comb begin
            shifted = {rem_in, 1'b0};
            diff    = shifted - {1'b0, den_in};
            ge      = shifted >= {1'b0, den_in};
            n_rem   = ge ? diff[NW-1:0] : shifted[NW-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_den[k] <= den_in;
                r_quo[k] <= {quo_in[QW-2:0], ge};
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

`default_nettype wire

/* hdl/sbc_sqrt_pipe.sv */
// ----------------------------------------------------------------------------
// sbc_sqrt_pipe
// Pipelined integer square root, one result bit per stage: returns
// floor(sqrt(value)) of a 2*DIR_BITS wide operand.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_sqrt_pipe (
    input  wire logic                               i_clk,
    input  wire logic                               i_en,
    input  wire logic [2*sbc_pkg::DIR_BITS-1:0]     i_val,
    output logic      [sbc_pkg::DIR_BITS-1:0]       o_root
);
    import sbc_pkg::*;

    localparam int RW = DIR_BITS;

    logic [2*RW-1:0] r_val  [RW];
    logic [RW+1:0]   r_rem  [RW];
    logic [RW-1:0]   r_root [RW];

    for (genvar k = 0; k < RW; k++) begin : g_step
        logic [2*RW-1:0] val_in;
        logic [RW+1:0]   rem_in;
        logic [RW-1:0]   root_in;
        logic [RW+2:0]   cat;
        logic [RW+2:0]   trial;
        logic [RW+2:0]   diff;
        logic            ge;

        if (k == 0) begin : g_first
            assign val_in  = i_val;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign val_in  = r_val[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end

        // Bring down the next two bits and try root*4+1
        always_comb begin
            cat   = {rem_in[RW:0], val_in[2*RW-1 -: 2]};
            trial = {1'b0, root_in, 2'b01};
            diff  = cat - trial;
            ge    = cat >= trial;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_val[k]  <= {val_in[2*RW-3:0], 2'b00};
                r_rem[k]  <= ge ? diff[RW+1:0] : cat[RW+1:0];
                r_root[k] <= {root_in[RW-2:0], ge};
            end
        end
    end

    assign o_root = r_root[RW-1];

endmodule

`default_nettype wire

/* hdl/swept_box_collision.sv */
// ----------------------------------------------------------------------------
// swept_box_collision
// Swept box against static box (slab test), with an overlap push-out when
// the mover does not move. One box pair in, one contact record out.
// ----------------------------------------------------------------------------
//
//  channel    dir  handshake                     payload
//  s_axis     in   i_s_axis_tvalid/o_s_axis_tready  static box, mover, move
//  m_axis     out  o_m_axis_tvalid/i_m_axis_tready  hit, time, end, contact,
//                                                   normal, push
//  cfg        in   i_cfg_wr_en                     time_margin
//
//  One transaction per cycle while the output is taken. At the default sizes
//  there are 4 setup stages, 3*DIR_BITS divide and square root stages of the
//  unit direction lanes and 4 finishing stages including the output register.
//  The whole pipeline advances together; it holds while the output register
//  is full and not taken. Synchronous reset clears valid bits and sets
//  time_margin to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module swept_box_collision #(
    parameter int COORD_WIDTH = 24,
    parameter int TIME_BITS   = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // static_x, static_y, static_half_w, static_half_h, mover_x, mover_y,
    // mover_half_w, mover_half_h, move_dx, move_dy (lowest first)
    input  wire logic [((10*COORD_WIDTH-4+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  wire logic                     i_m_axis_tready,
    // hit, hit_time, end_x, end_y, contact_x, contact_y, normal_x,
    // normal_y, push_x, push_y (lowest first)
    output logic [((6*COORD_WIDTH+TIME_BITS+12+7)/8)*8-1:0] o_m_axis_tdata,
    input  wire logic                     i_cfg_wr_en,
    input  wire logic [TIME_BITS:0]       i_cfg_wr_data
);
    import sbc_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int TB     = TIME_BITS;
    localparam int OW     = CW + 1;
    localparam int XW     = CW + 3;
    localparam int PW     = CW + TB + 2;
    localparam int HW     = CW + DIR_BITS;
    localparam int OUT_W  = 6 * CW + TB + 12;
    localparam int OUT_BW = ((OUT_W + 7) / 8) * 8;
    localparam int TDLY   = DIR_LAT - TB;
    localparam logic [TB:0] T_ONE = (TB+1)'(1) << TB;
    localparam logic [DIR_BITS:0] DIR_ONE = (DIR_BITS+1)'(1) << DIR_BITS;

    // ------------------------------------------------------------------------
    // Stage types
    // ------------------------------------------------------------------------
    typedef struct packed {
        logic                 vld;
        logic signed [CW-1:0] sx, sy, mx, my, dx, dy;
        logic [CW-2:0]        shw, shh, mhw, mhh;
    } t_s0;

    typedef struct packed {
        t_s0                  b;
        logic signed [CW+1:0] nnx, nfx, nny, nfy;
        logic [CW-1:0]        ax, ay;
        logic                 insx, insy;
        logic signed [CW+1:0] ox, oy;
        logic                 snx, sny;
    } t_s1;

    typedef struct packed {
        t_s1                  a;
        logic [2*CW:0]        p_nnx_ay, p_nfy_ax, p_nny_ax, p_nfx_ay;
        logic [2*CW-1:0]      a2, b2;
    } t_s2;

    typedef struct packed {
        logic                 vld;
        logic                 moving, shit, xnear, dxz, dyz;
        logic signed [CW-1:0] sx, sy, mx, my, dx, dy;
        logic [CW-2:0]        shw, shh, mhw, mhh;
        logic                 st_hit, st_x, st_neg;
        logic signed [CW+1:0] st_ov;
    } t_pay;

    typedef struct packed {
        logic [2*CW-1:0]      numx, numy, len;
        logic [CW-1:0]        tnum, tden;
    } t_div;

    typedef struct packed {
        t_pay                 p;
        logic [TB:0]          ts, omt;
        logic [TB-1:0]        traw;
        logic [DIR_BITS:0]    cdx, cdy;
    } t_p1;

    typedef struct packed {
        t_pay                 p;
        logic [TB:0]          ts;
        logic signed [PW-1:0] pe_x, pe_y, pp_x, pp_y, pt_x, pt_y;
        logic [HW-1:0]        ph_x, ph_y;
    } t_p2;

    typedef struct packed {
        t_pay                 p;
        logic [TB:0]          ts;
        logic signed [XW-1:0] exh, eyh, exm, eym, px, py;
        logic signed [XW-1:0] cxr, cyr, lox, hix, loy, hiy;
        logic signed [XW-1:0] st_push, st_c;
    } t_p3;

    typedef struct packed {
        logic                 vld;
        logic                 hit;
        logic [TB:0]          tm;
        logic [OW-1:0]        ex, ey, cx, cy;
        t_norm                nx, ny;
        logic [OW-1:0]        px, py;
    } t_out;

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------
    function automatic logic [CW:0] mag_n(input logic signed [CW+1:0] v);
        logic signed [CW+1:0] m;
        m = v[CW+1] ? -v : v;
        return m[CW:0];
    endfunction

    // true when n1/a1 > n2/a2, given the two cross products
    function automatic logic q_gt(input logic n1, input logic n2,
                                  input logic [2*CW:0] p, input logic [2*CW:0] q);
        return (!n1 && n2) || ((n1 == n2) && (n1 ? (p < q) : (p > q)));
    endfunction

    function automatic logic signed [XW-1:0] clamp_x(input logic signed [XW-1:0] v,
                                                     input logic signed [XW-1:0] lo,
                                                     input logic signed [XW-1:0] hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // ------------------------------------------------------------------------
    // Pipeline control and configuration
    // ------------------------------------------------------------------------
    logic        en;
    logic [TB:0] r_time_margin;
    t_s0  r_s0, n_s0;
    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    t_pay r_s3, n_s3;
    t_div r_dv, n_dv;
    t_pay r_dly [DIR_LAT];
    logic [TB-1:0] r_tdly [TDLY];
    t_p1  r_p1, n_p1;
    t_p2  r_p2, n_p2;
    t_p3  r_p3, n_p3;
    t_out r_out, n_out;
    logic [2*DIR_BITS-1:0] quo_x, quo_y;
    logic [DIR_BITS-1:0]   root_x, root_y;
    logic [TB-1:0]         traw_q;

    assign en              = !r_out.vld || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_out.vld;

    // Hold the margin register; writes must arrive only while idle, which the block does not enforce
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_margin <= (TB+1)'(1);
        end else if (i_cfg_wr_en) begin
            r_time_margin <= i_cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 0: unpack the transaction
    // ------------------------------------------------------------------------
    always_comb begin
        n_s0.vld = i_s_axis_tvalid;
        n_s0.sx  = i_s_axis_tdata[0 +: CW];
        n_s0.sy  = i_s_axis_tdata[CW +: CW];
        n_s0.shw = i_s_axis_tdata[2*CW +: CW-1];
        n_s0.shh = i_s_axis_tdata[3*CW-1 +: CW-1];
        n_s0.mx  = i_s_axis_tdata[4*CW-2 +: CW];
        n_s0.my  = i_s_axis_tdata[5*CW-2 +: CW];
        n_s0.mhw = i_s_axis_tdata[6*CW-2 +: CW-1];
        n_s0.mhh = i_s_axis_tdata[7*CW-3 +: CW-1];
        n_s0.dx  = i_s_axis_tdata[8*CW-4 +: CW];
        n_s0.dy  = i_s_axis_tdata[9*CW-4 +: CW];
    end

    // ------------------------------------------------------------------------
    // Stage 1: slab edge numerators, overlaps, move magnitudes
    // ------------------------------------------------------------------------
    always_comb begin
        logic signed [CW:0]   dsx, dsy;
        logic signed [CW+1:0] gx, gy;
        logic [CW:0]          adx, ady;
        logic [CW-1:0]        wx, wy;
        dsx = {r_s0.sx[CW-1], r_s0.sx} - {r_s0.mx[CW-1], r_s0.mx};
        dsy = {r_s0.sy[CW-1], r_s0.sy} - {r_s0.my[CW-1], r_s0.my};
        gx  = r_s0.dx[CW-1] ? -{dsx[CW], dsx} : {dsx[CW], dsx};
        gy  = r_s0.dy[CW-1] ? -{dsy[CW], dsy} : {dsy[CW], dsy};
        wx  = CW'({1'b0, r_s0.shw}) + CW'({1'b0, r_s0.mhw});
        wy  = CW'({1'b0, r_s0.shh}) + CW'({1'b0, r_s0.mhh});
        adx = dsx[CW] ? (CW+1)'(-dsx) : dsx;
        ady = dsy[CW] ? (CW+1)'(-dsy) : dsy;

        n_s1.b    = r_s0;
        n_s1.nnx  = gx - $signed({2'b00, wx});
        n_s1.nfx  = gx + $signed({2'b00, wx});
        n_s1.nny  = gy - $signed({2'b00, wy});
        n_s1.nfy  = gy + $signed({2'b00, wy});
        n_s1.ax   = r_s0.dx[CW-1] ? CW'(-r_s0.dx) : r_s0.dx;
        n_s1.ay   = r_s0.dy[CW-1] ? CW'(-r_s0.dy) : r_s0.dy;
        n_s1.insx = adx < {1'b0, wx};
        n_s1.insy = ady < {1'b0, wy};
        n_s1.ox   = $signed({2'b00, wx}) - $signed({1'b0, adx});
        n_s1.oy   = $signed({2'b00, wy}) - $signed({1'b0, ady});
        n_s1.snx  = !dsx[CW] && (dsx != '0);
        n_s1.sny  = !dsy[CW] && (dsy != '0);
    end

    // ------------------------------------------------------------------------
    // Stage 2: cross products for the time compares, squared move
    // ------------------------------------------------------------------------
    always_comb begin
        n_s2.a        = r_s1;
        n_s2.p_nnx_ay = (2*CW+1)'(mag_n(r_s1.nnx)) * (2*CW+1)'(r_s1.ay);
        n_s2.p_nfy_ax = (2*CW+1)'(mag_n(r_s1.nfy)) * (2*CW+1)'(r_s1.ax);
        n_s2.p_nny_ax = (2*CW+1)'(mag_n(r_s1.nny)) * (2*CW+1)'(r_s1.ax);
        n_s2.p_nfx_ay = (2*CW+1)'(mag_n(r_s1.nfx)) * (2*CW+1)'(r_s1.ay);
        n_s2.a2       = (2*CW)'(r_s1.ax) * (2*CW)'(r_s1.ax);
        n_s2.b2       = (2*CW)'(r_s1.ay) * (2*CW)'(r_s1.ay);
    end

    // ------------------------------------------------------------------------
    // Stage 3: pick near and far slabs, decide the hit, set up the dividers
    // ------------------------------------------------------------------------
    always_comb begin
        logic                 gt1, gt2, xn, flt, both, ok;
        logic signed [CW+1:0] nn, nf;
        logic [CW-1:0]        an;
        t_s0                  b;
        b    = r_s2.a.b;
        gt1  = q_gt(r_s2.a.nnx[CW+1], r_s2.a.nfy[CW+1], r_s2.p_nnx_ay, r_s2.p_nfy_ax);
        gt2  = q_gt(r_s2.a.nny[CW+1], r_s2.a.nfx[CW+1], r_s2.p_nny_ax, r_s2.p_nfx_ay);
        xn   = q_gt(r_s2.a.nnx[CW+1], r_s2.a.nny[CW+1], r_s2.p_nnx_ay, r_s2.p_nny_ax);
        flt  = q_gt(r_s2.a.nfy[CW+1], r_s2.a.nfx[CW+1], r_s2.p_nfy_ax, r_s2.p_nfx_ay);

        n_s3.dxz = (b.dx == '0);
        n_s3.dyz = (b.dy == '0);
        both     = !n_s3.dxz && !n_s3.dyz;
        ok       = (!n_s3.dxz || r_s2.a.insx) && (!n_s3.dyz || r_s2.a.insy) &&
                   !(both && (gt1 || gt2));

        if (both) begin
            n_s3.xnear = xn;
            nn         = xn ? r_s2.a.nnx : r_s2.a.nny;
            an         = xn ? r_s2.a.ax : r_s2.a.ay;
            nf         = flt ? r_s2.a.nfx : r_s2.a.nfy;
        end else if (!n_s3.dxz) begin
            n_s3.xnear = 1'b1;
            nn         = r_s2.a.nnx;
            an         = r_s2.a.ax;
            nf         = r_s2.a.nfx;
        end else begin
            n_s3.xnear = 1'b0;
            nn         = r_s2.a.nny;
            an         = r_s2.a.ay;
            nf         = r_s2.a.nfy;
        end

        n_s3.vld    = b.vld;
        n_s3.moving = !(n_s3.dxz && n_s3.dyz);
        n_s3.shit   = n_s3.moving && ok && (nn < $signed({2'b00, an})) &&
                      (nf > $signed((CW+2)'(0)));
        n_s3.sx     = b.sx;
        n_s3.sy     = b.sy;
        n_s3.mx     = b.mx;
        n_s3.my     = b.my;
        n_s3.dx     = b.dx;
        n_s3.dy     = b.dy;
        n_s3.shw    = b.shw;
        n_s3.shh    = b.shh;
        n_s3.mhw    = b.mhw;
        n_s3.mhh    = b.mhh;

        // Overlap push-out: smaller overlap wins, ties go to y
        n_s3.st_hit = (r_s2.a.ox > $signed((CW+2)'(0))) &&
                      (r_s2.a.oy > $signed((CW+2)'(0)));
        n_s3.st_x   = r_s2.a.ox < r_s2.a.oy;
        n_s3.st_neg = n_s3.st_x ? r_s2.a.snx : r_s2.a.sny;
        n_s3.st_ov  = n_s3.st_x ? r_s2.a.ox : r_s2.a.oy;

        n_dv.numx = r_s2.a2;
        n_dv.numy = r_s2.b2;
        n_dv.len  = r_s2.a2 + r_s2.b2;
        n_dv.tnum = (nn > $signed((CW+2)'(0))) ? nn[CW-1:0] : '0;
        n_dv.tden = an;
    end

    // ------------------------------------------------------------------------
    // Setup stage registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.vld <= 1'b0;
            r_s1.b.vld <= 1'b0;
            r_s2.a.b.vld <= 1'b0;
            r_s3.vld <= 1'b0;
        end else if (en) begin
            r_s0 <= n_s0;
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv <= n_dv;
        end
    end

    // ------------------------------------------------------------------------
    // Hit time and unit direction lanes
    // ------------------------------------------------------------------------
    sbc_div_pipe #(.NW(CW), .QW(TB)) u_div_t (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_dv.tnum),
        .i_den (r_dv.tden),
        .o_quo (traw_q)
    );

    sbc_div_pipe #(.NW(2*CW), .QW(DIV_STEPS)) u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_dv.numx),
        .i_den (r_dv.len),
        .o_quo (quo_x)
    );

    sbc_div_pipe #(.NW(2*CW), .QW(DIV_STEPS)) u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_dv.numy),
        .i_den (r_dv.len),
        .o_quo (quo_y)
    );

    sbc_sqrt_pipe u_sqrt_x (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (quo_x),
        .o_root (root_x)
    );

    sbc_sqrt_pipe u_sqrt_y (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (quo_y),
        .o_root (root_y)
    );

    // Carry the item alongside the lanes
    for (genvar k = 0; k < DIR_LAT; k++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dly[k].vld <= 1'b0;
            end else if (en) begin
                r_dly[k] <= (k == 0) ? r_s3 : r_dly[(k == 0) ? 0 : k-1];
            end
        end
    end

    for (genvar k = 0; k < TDLY; k++) begin : g_tdly
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_tdly[k] <= (k == 0) ? traw_q : r_tdly[(k == 0) ? 0 : k-1];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Finish 1: margin, remaining time, direction select
    // ------------------------------------------------------------------------
    always_comb begin
        logic signed [TB+1:0] diff;
        logic [TB-1:0]        traw;
        t_pay                 p;
        p    = r_dly[DIR_LAT-1];
        traw = r_tdly[TDLY-1];
        diff = $signed({2'b00, traw}) - $signed({1'b0, r_time_margin});

        n_p1.p    = p;
        n_p1.traw = traw;
        n_p1.ts   = diff[TB+1] ? '0 : diff[TB:0];
        n_p1.omt  = T_ONE - {1'b0, traw};
        n_p1.cdx  = p.dxz ? '0 : (p.dyz ? DIR_ONE : {1'b0, root_x});
        n_p1.cdy  = p.dyz ? '0 : (p.dxz ? DIR_ONE : {1'b0, root_y});
    end

    // ------------------------------------------------------------------------
    // Finish 2: scale the move and the mover half size
    // ------------------------------------------------------------------------
    always_comb begin
        logic signed [PW-1:0] dxp, dyp, tsp, omp, trp;
        dxp = PW'(r_p1.p.dx);
        dyp = PW'(r_p1.p.dy);
        tsp = PW'($signed({1'b0, r_p1.ts}));
        omp = PW'($signed({1'b0, r_p1.omt}));
        trp = PW'($signed({2'b00, r_p1.traw}));

        n_p2.p    = r_p1.p;
        n_p2.ts   = r_p1.ts;
        n_p2.pe_x = dxp * tsp;
        n_p2.pe_y = dyp * tsp;
        n_p2.pp_x = dxp * omp;
        n_p2.pp_y = dyp * omp;
        n_p2.pt_x = dxp * trp;
        n_p2.pt_y = dyp * trp;
        n_p2.ph_x = HW'(r_p1.p.mhw) * HW'(r_p1.cdx);
        n_p2.ph_y = HW'(r_p1.p.mhh) * HW'(r_p1.cdy);
    end

    // ------------------------------------------------------------------------
    // Finish 3: floor the products, sum positions, bounds
    // ------------------------------------------------------------------------
    always_comb begin
        logic signed [PW-1:0] se_x, se_y, sp_x, sp_y, st_x, st_y;
        logic signed [XW-1:0] ofx, ofy, mxw, myw, sxw, syw, shw, shh, ov;
        t_pay                 p;
        p    = r_p2.p;
        se_x = r_p2.pe_x >>> TB;
        se_y = r_p2.pe_y >>> TB;
        sp_x = (-r_p2.pp_x) >>> TB;
        sp_y = (-r_p2.pp_y) >>> TB;
        st_x = r_p2.pt_x >>> TB;
        st_y = r_p2.pt_y >>> TB;
        ofx  = $signed({4'b0000, r_p2.ph_x[DIR_BITS +: CW-1]});
        ofy  = $signed({4'b0000, r_p2.ph_y[DIR_BITS +: CW-1]});
        if (p.dx[CW-1]) begin
            ofx = -ofx;
        end
        if (p.dy[CW-1]) begin
            ofy = -ofy;
        end
        mxw  = XW'(p.mx);
        myw  = XW'(p.my);
        sxw  = XW'(p.sx);
        syw  = XW'(p.sy);
        shw  = $signed({4'b0000, p.shw});
        shh  = $signed({4'b0000, p.shh});
        ov   = XW'(p.st_ov);

        n_p3.p       = p;
        n_p3.ts      = r_p2.ts;
        n_p3.exh     = mxw + $signed(se_x[XW-1:0]);
        n_p3.eyh     = myw + $signed(se_y[XW-1:0]);
        n_p3.exm     = p.moving ? (mxw + XW'(p.dx)) : mxw;
        n_p3.eym     = p.moving ? (myw + XW'(p.dy)) : myw;
        n_p3.px      = $signed(sp_x[XW-1:0]);
        n_p3.py      = $signed(sp_y[XW-1:0]);
        n_p3.cxr     = mxw + $signed(st_x[XW-1:0]) + ofx;
        n_p3.cyr     = myw + $signed(st_y[XW-1:0]) + ofy;
        n_p3.lox     = sxw - shw;
        n_p3.hix     = sxw + shw;
        n_p3.loy     = syw - shh;
        n_p3.hiy     = syw + shh;
        n_p3.st_push = p.st_neg ? -ov : ov;
        if (p.st_x) begin
            n_p3.st_c = p.st_neg ? (sxw - shw) : (sxw + shw);
        end else begin
            n_p3.st_c = p.st_neg ? (syw - shh) : (syw + shh);
        end
    end

    // ------------------------------------------------------------------------
    // Finish 4: clamp the contact and select the result
    // ------------------------------------------------------------------------
    always_comb begin
        logic signed [XW-1:0] cxc, cyc;
        t_pay                 p;
        p   = r_p3.p;
        cxc = clamp_x(r_p3.cxr, r_p3.lox, r_p3.hix);
        cyc = clamp_x(r_p3.cyr, r_p3.loy, r_p3.hiy);

        n_out.vld = p.vld;
        n_out.hit = 1'b0;
        n_out.tm  = T_ONE;
        n_out.ex  = r_p3.exm[OW-1:0];
        n_out.ey  = r_p3.eym[OW-1:0];
        n_out.cx  = '0;
        n_out.cy  = '0;
        n_out.nx  = NORM_NONE;
        n_out.ny  = NORM_NONE;
        n_out.px  = '0;
        n_out.py  = '0;
        if (p.moving && p.shit) begin
            n_out.hit = 1'b1;
            n_out.tm  = r_p3.ts;
            n_out.ex  = r_p3.exh[OW-1:0];
            n_out.ey  = r_p3.eyh[OW-1:0];
            n_out.cx  = cxc[OW-1:0];
            n_out.cy  = cyc[OW-1:0];
            n_out.px  = r_p3.px[OW-1:0];
            n_out.py  = r_p3.py[OW-1:0];
            if (p.xnear) begin
                n_out.nx = p.dx[CW-1] ? NORM_POS : NORM_NEG;
            end else begin
                n_out.ny = p.dy[CW-1] ? NORM_POS : NORM_NEG;
            end
        end else if (!p.moving && p.st_hit) begin
            n_out.hit = 1'b1;
            n_out.tm  = '0;
            if (p.st_x) begin
                n_out.px = r_p3.st_push[OW-1:0];
                n_out.nx = p.st_neg ? NORM_NEG : NORM_POS;
                n_out.cx = r_p3.st_c[OW-1:0];
                n_out.cy = OW'(p.my);
            end else begin
                n_out.py = r_p3.st_push[OW-1:0];
                n_out.ny = p.st_neg ? NORM_NEG : NORM_POS;
                n_out.cx = OW'(p.mx);
                n_out.cy = r_p3.st_c[OW-1:0];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Finishing stage registers and output register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1.p.vld <= 1'b0;
            r_p2.p.vld <= 1'b0;
            r_p3.p.vld <= 1'b0;
            r_out.vld  <= 1'b0;
        end else if (en) begin
            r_p1  <= n_p1;
            r_p2  <= n_p2;
            r_p3  <= n_p3;
            r_out <= n_out;
        end
    end

    assign o_m_axis_tdata = OUT_BW'({r_out.py, r_out.px, r_out.ny, r_out.nx,
                                     r_out.cy, r_out.cx, r_out.ey, r_out.ex,
                                     r_out.tm, r_out.hit});

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_miss_fields : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out.vld && !r_out.hit) |->
            (r_out.tm == T_ONE) && (r_out.nx == NORM_NONE) && (r_out.ny == NORM_NONE) &&
            (r_out.px == '0) && (r_out.py == '0))
        else $error("miss carries contact data");

    a_one_normal : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out.vld && r_out.hit) |-> ((r_out.nx != NORM_NONE) != (r_out.ny != NORM_NONE)))
        else $error("hit without exactly one normal axis");

    a_hit_time : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out.vld && r_out.hit) |-> (r_out.tm < T_ONE))
        else $error("hit time not below one");

    a_stall_keep : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p3.p.vld && !en) |=> r_p3.p.vld)
        else $error("item dropped during stall");

    a_reset_clear : assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out.vld)
        else $error("output valid after reset");

endmodule

`default_nettype wire

/* verif/swept_box_collision_checker.sv */
// ----------------------------------------------------------------------------
// swept_box_collision_checker
// Watches the box pair, contact record and margin write channels, predicts
// each contact record from the accepted box pair and compares field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module swept_box_collision_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_valid,
    input  wire logic         i_s_ready,
    input  wire logic [239:0] i_s_data,
    input  wire logic         i_m_valid,
    input  wire logic         i_m_ready,
    input  wire logic [175:0] i_m_data,
    input  wire logic         i_cfg_wr_en,
    input  wire logic [16:0]  i_cfg_wr_data,
    output int                o_errors,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint T_ONE = 64'sd65536;

    typedef struct packed {
        logic        hit;
        logic [16:0] hit_time;
        logic [24:0] end_x, end_y, contact_x, contact_y;
        logic [1:0]  normal_x, normal_y;
        logic [24:0] push_x, push_y;
    } t_contact;

    t_contact    contact_q[$];
    logic [16:0] margin;

    function automatic longint unsigned mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Sign of n1/a1 - n2/a2 for positive a1, a2
    function automatic int ratio_cmp(longint n1, longint a1, longint n2, longint a2);
        longint unsigned p, q;
        int c;
        if (n1 < 0 && n2 >= 0) return -1;
        if (n1 >= 0 && n2 < 0) return 1;
        p = mag(n1) * a2;
        q = mag(n2) * a1;
        c = p > q ? 1 : (p < q ? -1 : 0);
        return n1 < 0 ? -c : c;
    endfunction

    // Floor of coordinate times Q1.16 time
    function automatic longint scale_time(longint d, longint t);
        longint p;
        p = d * t;
        if (p >= 0) return p >>> 16;
        return -longint'((mag(p) + 65535) >> 16);
    endfunction

    // Half size times unit direction component along a, truncated toward zero
    function automatic longint half_along(longint a, longint b, longint half);
        longint unsigned a2, l, r, q, c, res, bt;
        longint off;
        a2 = mag(a) * mag(a);
        l  = a2 + mag(b) * mag(b);
        if (a == 0 || l == 0) return 0;
        if (a2 >= l) begin
            c = 64'd1 << 16;
        end else begin
            r = a2;
            q = 0;
            for (int i = 0; i < 32; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= l) begin
                    r = r - l;
                    q = q | 1;
                end
            end
            res = 0;
            bt  = 64'd1 << 62;
            while (bt > q) bt = bt >> 2;
            while (bt != 0) begin
                if (q >= res + bt) begin
                    q   = q - (res + bt);
                    res = (res >> 1) + bt;
                end else begin
                    res = res >> 1;
                end
                bt = bt >> 2;
            end
            c = res;
        end
        off = longint'((longint'(half) * c) >> 16);
        return a < 0 ? -off : off;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic t_contact predict_contact(logic [239:0] d, logic [16:0] m);
        t_contact res;
        longint sx, sy, shw, shh, mx, my, mhw, mhh, dx, dy, wx, wy;
        longint hit, tout, ex, ey, cx, cy, nx, ny, px, py;
        longint ddx, ddy, ox, oy, s, sgx, sgy, ax, ay, nnx, nfx, nny, nfy, nn, an, nf;
        longint traw, ts;
        bit ok, xnear;
        sx  = longint'($signed(d[23:0]));
        sy  = longint'($signed(d[47:24]));
        shw = longint'(d[70:48]);
        shh = longint'(d[93:71]);
        mx  = longint'($signed(d[117:94]));
        my  = longint'($signed(d[141:118]));
        mhw = longint'(d[164:142]);
        mhh = longint'(d[187:165]);
        dx  = longint'($signed(d[211:188]));
        dy  = longint'($signed(d[235:212]));
        wx = shw + mhw;
        wy = shh + mhh;
        hit = 0; tout = T_ONE; ex = mx + dx; ey = my + dy;
        cx = 0; cy = 0; nx = 0; ny = 0; px = 0; py = 0;
        if (dx == 0 && dy == 0) begin
            // Overlap test, push out along the axis of least overlap
            ddx = mx - sx;
            ddy = my - sy;
            ox = wx - longint'(mag(ddx));
            oy = wy - longint'(mag(ddy));
            ex = mx;
            ey = my;
            if (ox > 0 && oy > 0) begin
                hit = 1;
                tout = 0;
                if (ox < oy) begin
                    s = ddx < 0 ? -1 : 1;
                    px = ox * s; nx = s; cx = sx + shw * s; cy = my;
                end else begin
                    s = ddy < 0 ? -1 : 1;
                    py = oy * s; ny = s; cx = mx; cy = sy + shh * s;
                end
            end
        end else begin
            // Slab test against the widened static box
            ok = 1;
            sgx = dx < 0 ? -1 : 1;
            sgy = dy < 0 ? -1 : 1;
            ax = longint'(mag(dx));
            ay = longint'(mag(dy));
            nnx = sgx * (sx - mx) - wx; nfx = sgx * (sx - mx) + wx;
            nny = sgy * (sy - my) - wy; nfy = sgy * (sy - my) + wy;
            if (dx == 0 && !(longint'(mag(sx - mx)) < wx)) ok = 0;
            if (dy == 0 && !(longint'(mag(sy - my)) < wy)) ok = 0;
            if (dx != 0 && dy != 0) begin
                if (ratio_cmp(nnx, ax, nfy, ay) > 0 || ratio_cmp(nny, ay, nfx, ax) > 0)
                    ok = 0;
                xnear = ratio_cmp(nnx, ax, nny, ay) > 0;
                nn = xnear ? nnx : nny;
                an = xnear ? ax : ay;
                nf = ratio_cmp(nfx, ax, nfy, ay) < 0 ? nfx : nfy;
            end else if (dx != 0) begin
                xnear = 1; nn = nnx; an = ax; nf = nfx;
            end else begin
                xnear = 0; nn = nny; an = ay; nf = nfy;
            end
            if (ok && nn < an && nf > 0) begin
                traw = nn <= 0 ? 0 : (nn <<< 16) / an;
                ts = clip(traw - longint'(m), 0, T_ONE);
                hit = 1;
                tout = ts;
                if (xnear) nx = -sgx; else ny = -sgy;
                px = scale_time(-dx, T_ONE - traw);
                py = scale_time(-dy, T_ONE - traw);
                ex = mx + scale_time(dx, ts);
                ey = my + scale_time(dy, ts);
                cx = clip(mx + scale_time(dx, traw) + half_along(dx, dy, mhw),
                          sx - shw, sx + shw);
                cy = clip(my + scale_time(dy, traw) + half_along(dy, dx, mhh),
                          sy - shh, sy + shh);
            end
        end
        res.hit       = hit[0];
        res.hit_time  = tout[16:0];
        res.end_x     = ex[24:0];
        res.end_y     = ey[24:0];
        res.contact_x = cx[24:0];
        res.contact_y = cy[24:0];
        res.normal_x  = nx[1:0];
        res.normal_y  = ny[1:0];
        res.push_x    = px[24:0];
        res.push_y    = py[24:0];
        return res;
    endfunction

    assign o_pending = contact_q.size();

    // Track margin, queue predictions, compare records
    always @(posedge i_clk) begin
        t_contact exp_c, got;
        if (!i_rst_n) begin
            margin   <= 17'd1;
            o_errors <= 0;
        end else begin
            if (i_cfg_wr_en) margin <= i_cfg_wr_data;
            if (i_s_valid && i_s_ready) contact_q.push_back(predict_contact(i_s_data, margin));
            if (i_m_valid && i_m_ready) begin
                got.hit       = i_m_data[0];
                got.hit_time  = i_m_data[17:1];
                got.end_x     = i_m_data[42:18];
                got.end_y     = i_m_data[67:43];
                got.contact_x = i_m_data[92:68];
                got.contact_y = i_m_data[117:93];
                got.normal_x  = i_m_data[119:118];
                got.normal_y  = i_m_data[121:120];
                got.push_x    = i_m_data[146:122];
                got.push_y    = i_m_data[171:147];
                if (contact_q.size() == 0) begin
                    $error("contact record with none expected");
                    o_errors <= o_errors + 1;
                end else begin
                    exp_c = contact_q.pop_front();
                    if (got != exp_c) begin
                        o_errors <= o_errors + 1;
                        if (got.hit != exp_c.hit)
                            $error("hit exp %0d got %0d", exp_c.hit, got.hit);
                        if (got.hit_time != exp_c.hit_time)
                            $error("hit_time exp %0d got %0d", exp_c.hit_time, got.hit_time);
                        if (got.end_x != exp_c.end_x)
                            $error("end_x exp %0d got %0d", $signed(exp_c.end_x),
                                   $signed(got.end_x));
                        if (got.end_y != exp_c.end_y)
                            $error("end_y exp %0d got %0d", $signed(exp_c.end_y),
                                   $signed(got.end_y));
                        if (got.contact_x != exp_c.contact_x)
                            $error("contact_x exp %0d got %0d", $signed(exp_c.contact_x),
                                   $signed(got.contact_x));
                        if (got.contact_y != exp_c.contact_y)
                            $error("contact_y exp %0d got %0d", $signed(exp_c.contact_y),
                                   $signed(got.contact_y));
                        if (got.normal_x != exp_c.normal_x)
                            $error("normal_x exp %0d got %0d", $signed(exp_c.normal_x),
                                   $signed(got.normal_x));
                        if (got.normal_y != exp_c.normal_y)
                            $error("normal_y exp %0d got %0d", $signed(exp_c.normal_y),
                                   $signed(got.normal_y));
                        if (got.push_x != exp_c.push_x)
                            $error("push_x exp %0d got %0d", $signed(exp_c.push_x),
                                   $signed(got.push_x));
                        if (got.push_y != exp_c.push_y)
                            $error("push_y exp %0d got %0d", $signed(exp_c.push_y),
                                   $signed(got.push_y));
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

/* verif/tb_swept_box_collision.sv */
// ----------------------------------------------------------------------------
// tb_swept_box_collision
// Drives box pairs through the collision pipeline with directed corner cases
// and random sweeps under several time margins, with random stalls on both
// channels, and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_swept_box_collision;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WD_LIMIT = 5000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_valid, s_ready;
    logic [239:0] s_data;
    logic         m_valid, m_ready;
    logic [175:0] m_data;
    logic         cfg_wr_en;
    logic [16:0]  cfg_wr_data;
    int           errors, pending;
    bit           quiet;
    bit           hold_req;
    int           idle_cycles;

    swept_box_collision u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data)
    );

    swept_box_collision_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_valid     (s_valid),
        .i_s_ready     (s_ready),
        .i_s_data      (s_data),
        .i_m_valid     (m_valid),
        .i_m_ready     (m_ready),
        .i_m_data      (m_data),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Pack one box pair, static_x in the lowest bits
    function automatic logic [239:0] pack_pair(int sx, int sy, int shw, int shh, int mx,
                                               int my, int mhw, int mhh, int dx, int dy);
        return {4'b0, dy[23:0], dx[23:0], mhh[22:0], mhw[22:0], my[23:0], mx[23:0],
                shh[22:0], shw[22:0], sy[23:0], sx[23:0]};
    endfunction

    function automatic int small_coord();
        return $urandom_range(0, 8192) - 4096;
    endfunction

    // Random pair: mostly small boxes near each other, some full-range noise
    function automatic logic [239:0] random_pair();
        int mode, dx, dy;
        logic [31:0] tail;
        mode = $urandom_range(0, 99);
        tail = $urandom;
        if (mode < 10)
            return {4'b0, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, tail[11:0]};
        dx = small_coord() * 2;
        dy = small_coord() * 2;
        if (mode < 30) begin
            dx = 0;
            dy = 0;
        end else if (mode < 40) begin
            dx = 0;
        end else if (mode < 50) begin
            dy = 0;
        end
        return pack_pair(small_coord(), small_coord(), $urandom_range(0, 2048),
                         $urandom_range(0, 2048), small_coord(), small_coord(),
                         $urandom_range(0, 2048), $urandom_range(0, 2048), dx, dy);
    endfunction

    // Offer one pair, with a random gap first unless quiet
    task automatic send_pair(logic [239:0] d);
        bit taken;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        do begin
            @(negedge i_clk);
            taken = s_valid && s_ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        wait (pending == 0);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_margin(logic [16:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        @(posedge i_clk);
    endtask

    // Result side: random stall bursts, one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_req = 0;
            end
            if (quiet || $urandom_range(0, 3) != 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7) - 1) @(posedge i_clk);
            end
        end
    end

    // Stop on a long stretch without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        logic [16:0] margins[5];
        s_valid     <= 1'b0;
        s_data      <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        i_rst_n     <= 1'b0;
        quiet    = 0;
        hold_req = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners under the reset margin
        send_pair(pack_pair(8388607, 8388607, 8388607, 8388607, -8388608, -8388608,
                            8388607, 8388607, 8388607, 8388607));
        send_pair(pack_pair(-8388608, -8388608, 0, 0, 8388607, 8388607,
                            0, 0, -8388608, -8388608));
        send_pair(pack_pair(0, 0, 256, 256, 100, 50, 256, 256, 0, 0));
        send_pair(pack_pair(0, 0, 256, 256, 50, 100, 256, 256, 0, 0));
        send_pair(pack_pair(0, 0, 256, 256, 0, 0, 256, 256, 0, 0));
        send_pair(pack_pair(0, 0, 256, 256, -60, -60, 256, 256, 0, 0));
        send_pair(pack_pair(0, 0, 256, 256, 1024, 0, 256, 256, 0, 0));
        send_pair(pack_pair(0, 0, 256, 256, -2048, 0, 256, 256, 4096, 0));
        send_pair(pack_pair(0, 0, 256, 256, -2048, 512, 256, 256, 4096, 0));
        send_pair(pack_pair(0, 0, 256, 256, 0, -2048, 256, 256, 0, 4096));
        send_pair(pack_pair(0, 0, 256, 256, -2048, 0, 256, 256, 1536, 0));
        send_pair(pack_pair(0, 0, 256, 256, 512, 0, 256, 256, 1024, 0));
        send_pair(pack_pair(0, 0, 256, 256, 100, 0, 256, 256, 300, 0));
        send_pair(pack_pair(0, 0, 256, 256, -2048, -2048, 256, 256, 4096, 4096));
        send_pair(pack_pair(0, 0, 256, 256, 2048, 2048, 128, 300, -3000, -4000));
        send_pair(pack_pair(0, 0, 256, 256, -2048, 600, 256, 256, 4096, -100));
        send_pair(pack_pair(0, 0, 256, 256, 0, 0, 0, 0, -8388608, 8388607));
        drain();

        margins[0] = 17'd0;
        margins[1] = 17'd65536;
        margins[2] = 17'($urandom_range(2, 65535));
        margins[3] = 17'd300;
        margins[4] = 17'd1;
        foreach (margins[p]) begin
            write_margin(margins[p]);
            if (p == 4) quiet = 1;
            for (int i = 0; i < 107; i++) begin
                if (p == 1 && i == 20) hold_req = 1;
                send_pair(random_pair());
            end
            drain();
        end

        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
